// ===== rtl/core/aeot_pkg.sv =====
// Shared constants, register codes and unit result types of the energy and onset tracker.
package aeot_pkg;

    // Log unit: Q16.16 argument, INT_BITS integer and FRAC_BITS fraction result bits
    localparam int FRAC_BITS  = 16;
    localparam int X_W        = 32;
    localparam int X_FRAC     = 16;
    localparam int INT_BITS   = 4;
    localparam int LOG_W      = INT_BITS + FRAC_BITS;
    localparam int LOG_CNT_W  = $clog2(FRAC_BITS);
    localparam int MANT_BITS  = 30;
    localparam int MANT_W     = MANT_BITS + 1;
    localparam int NORM_INIT  = X_W - 1 - X_FRAC;

    // Divider: 16 quotient bits, one per step
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Output levels
    localparam logic [15:0] GLOW_LEVEL = 16'd9830;
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    // Configuration reset values
    localparam logic [15:0] FLOOR_RST  = 16'd4000;
    localparam logic [15:0] BASE_RST   = 16'd50000;
    localparam logic [15:0] CDECAY_RST = 16'd65529;
    localparam logic [15:0] PDECAY_RST = 16'd65405;

    // Register indexes
    localparam logic [1:0] REG_FLOOR  = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_CDECAY = 2'd2;
    localparam logic [1:0] REG_PDECAY = 2'd3;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } t_log_res;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } t_div_res;

endpackage

// ===== rtl/core/aeot_log.sv =====
// Iterative log2 unit: normalizing shift search, then one mantissa squaring per cycle.
module aeot_log (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_x,
    output aeot_pkg::t_log_res       o_res
);
    import aeot_pkg::*;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ   = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [X_W-1:0]        r_x, n_x;
    logic [INT_BITS-1:0]   r_int, n_int;
    logic [MANT_W-1:0]     r_m, n_m;
    logic [LOG_W-1:0]      r_acc, n_acc;
    logic [LOG_CNT_W-1:0]  r_cnt, n_cnt;
    logic                  r_done, n_done;
    logic [2*MANT_W-1:0]   sq;
    logic [MANT_W:0]       t;

    // Square the mantissa and rescale back to Q1.30
    assign sq = (2*MANT_W)'(r_m) * (2*MANT_W)'(r_m);
    assign t  = sq[2*MANT_BITS+1:MANT_BITS];

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_int   = r_int;
        n_m     = r_m;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_x     = i_x;
                    n_int   = INT_BITS'(NORM_INIT);
                    n_state = L_NORM;
                end
            end
            L_NORM: begin
                // shift left until the top bit is set, coarse steps first
                priority if (r_x[X_W-1:X_W-8] == 8'd0) begin
                    n_x   = r_x << 8;
                    n_int = r_int - INT_BITS'(8);
                end else if (r_x[X_W-1:X_W-4] == 4'd0) begin
                    n_x   = r_x << 4;
                    n_int = r_int - INT_BITS'(4);
                end else if (!r_x[X_W-1]) begin
                    n_x   = r_x << 1;
                    n_int = r_int - INT_BITS'(1);
                end else begin
                    n_m     = r_x[X_W-1:X_W-MANT_W];
                    n_acc   = LOG_W'(r_int);
                    n_cnt   = '0;
                    n_state = L_SQ;
                end
            end
            L_SQ: begin
                // one fraction bit per squaring
                if (t[MANT_W]) begin
                    n_m   = t[MANT_W:1];
                    n_acc = {r_acc[LOG_W-2:0], 1'b1};
                end else begin
                    n_m   = t[MANT_W-1:0];
                    n_acc = {r_acc[LOG_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + LOG_CNT_W'(1);
                if (r_cnt == LOG_CNT_W'(FRAC_BITS - 1)) begin
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x   <= n_x;
        r_int <= n_int;
        r_m   <= n_m;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
    end

    assign o_res.done  = r_done;
    assign o_res.value = r_acc;

endmodule

// ===== rtl/core/aeot_div.sv =====
// Restoring divider, one quotient bit per cycle; dividend high part must be below the divisor.
module aeot_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_hi,
    input  logic [15:0]          i_lo,
    input  logic [31:0]          i_den,
    output aeot_pkg::t_div_res   o_res
);
    import aeot_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [31:0]           r_rem, n_rem;
    logic [31:0]           r_den, n_den;
    logic [15:0]           r_lo, n_lo;
    logic [15:0]           r_q, n_q;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [32:0]           rem2;
    logic [32:0]           diff;
    logic                  ge;

    // Trial subtract of the shifted remainder
    assign rem2 = {r_rem, r_lo[15]};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = (rem2 >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_den  = r_den;
        n_lo   = r_lo;
        n_q    = r_q;
        n_cnt  = r_cnt;
        if (!r_busy) begin
            if (i_start) begin
                n_rem  = i_hi;
                n_lo   = i_lo;
                n_den  = i_den;
                n_cnt  = '0;
                n_busy = 1'b1;
            end
        end else begin
            n_rem = ge ? diff[31:0] : rem2[31:0];
            n_q   = {r_q[14:0], ge};
            n_lo  = {r_lo[14:0], 1'b0};
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_lo  <= n_lo;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_q;

endmodule

// ===== rtl/core/audio_energy_onset_tracker_top.sv =====
// Energy and onset tracker top level: register port, sequencer, state and output register.
//
//  channel   direction  signals                                   transfer when
//  input     in         i_in_valid, o_in_stall, i_raw_rms,        i_in_valid && !o_in_stall
//                       i_mic_enabled
//  output    out        o_out_valid, i_out_stall,                 o_out_valid && !i_out_stall
//                       o_energy_level, o_onset_level
//  config    in/out     psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite
//                       prdata, pready
//
// A frame with the mic disabled goes from S_IDLE straight to S_OUT to wait for the output
// register. An enabled frame passes S_CEIL, S_PEAK and S_ECHK, then, unless the floor checks
// settle the energy, three log2 passes (up to 5 normalize shifts, a load, FRAC_BITS squarings
// on the log unit's multiplier, a hand-off), and up to two divisions before S_OUT.
// Synchronous active-low reset restores the register reset values and the tracker state.
// o_in_stall is high whenever the sequencer is busy; a result held by i_out_stall waits in the
// output register while the next frame is accepted and processed.
module audio_energy_onset_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_raw_rms,
    input  logic        i_mic_enabled,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_energy_level,
    output logic [15:0] o_onset_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aeot_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CEIL  = 4'd1;
    localparam logic [3:0] S_PEAK  = 4'd2;
    localparam logic [3:0] S_ECHK  = 4'd3;
    localparam logic [3:0] S_LF    = 4'd4;
    localparam logic [3:0] S_LR    = 4'd5;
    localparam logic [3:0] S_LC    = 4'd6;
    localparam logic [3:0] S_EDIV  = 4'd7;
    localparam logic [3:0] S_ONSET = 4'd8;
    localparam logic [3:0] S_ODIV  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // Configuration registers
    logic [15:0] r_floor, r_base, r_cdecay, r_pdecay;
    logic        cfg_wr;

    // Tracker state and working registers
    logic [3:0]        r_state, n_state;
    logic [31:0]       r_ceil, n_ceil;
    logic [15:0]       r_prev, n_prev;
    logic [31:0]       r_peak, n_peak;
    logic [15:0]       r_rms, n_rms;
    logic [15:0]       r_delta, n_delta;
    logic [LOG_W-1:0]  r_lf, n_lf;
    logic [LOG_W-1:0]  r_lr, n_lr;
    logic [15:0]       r_energy, n_energy;
    logic [15:0]       r_onset, n_onset;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_out_energy, n_out_energy;
    logic [15:0]       r_out_onset, n_out_onset;

    // Shared decay multiplier and unit hookups
    logic [31:0]          mul_a;
    logic [15:0]          mul_b;
    logic [47:0]          prod;
    logic [31:0]          decayed;
    logic                 log_start;
    logic [31:0]          log_x;
    t_log_res             log_res;
    logic                 div_start;
    logic [31:0]          div_hi;
    logic [15:0]          div_lo;
    logic [31:0]          div_den;
    t_div_res             div_res;

    logic [15:0]          floor_eff;
    logic [31:0]          floor_q;
    logic [31:0]          rms_q;
    logic [31:0]          base_q;
    logic [31:0]          ceil_dec;
    logic [15:0]          delta;
    logic [31:0]          dq;
    logic [LOG_W-1:0]     num;
    logic [LOG_W-1:0]     den;
    logic [LOG_W+15:0]    nmul;
    logic                 in_xfer;
    logic                 out_load;

    aeot_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_res   (log_res)
    );

    aeot_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_den   (div_den),
        .o_res   (div_res)
    );

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_FLOOR:  prdata = {16'd0, r_floor};
            REG_BASE:   prdata = {16'd0, r_base};
            REG_CDECAY: prdata = {16'd0, r_cdecay};
            REG_PDECAY: prdata = {16'd0, r_pdecay};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= FLOOR_RST;
            r_base   <= BASE_RST;
            r_cdecay <= CDECAY_RST;
            r_pdecay <= PDECAY_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FLOOR:  r_floor  <= pwdata[15:0];
                REG_BASE:   r_base   <= pwdata[15:0];
                REG_CDECAY: r_cdecay <= pwdata[15:0];
                REG_PDECAY: r_pdecay <= pwdata[15:0];
                default:    r_floor  <= r_floor;
            endcase
        end
    end

    // Decay product, shared between the ceiling and change-peak steps
    assign mul_a   = (r_state == S_CEIL) ? r_ceil : r_peak;
    assign mul_b   = (r_state == S_CEIL) ? r_cdecay : r_pdecay;
    assign prod    = 48'(mul_a) * 48'(mul_b);
    assign decayed = prod[47:16];

    assign floor_eff = (r_floor == 16'd0) ? 16'd1 : r_floor;
    assign floor_q   = {floor_eff, 16'd0};
    assign rms_q     = {r_rms, 16'd0};
    assign base_q    = {r_base, 16'd0};
    assign ceil_dec  = (decayed > base_q) ? decayed : base_q;
    assign delta     = (r_rms >= r_prev) ? (r_rms - r_prev) : (r_prev - r_rms);
    assign dq        = {delta, 16'd0};

    // Energy quotient operands once all three logs are in
    assign den  = log_res.value - r_lf;
    assign num  = (r_lr > r_lf) ? (r_lr - r_lf) : '0;
    assign nmul = {num, 16'd0} - (LOG_W+16)'(num);

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_ceil    = r_ceil;
        n_prev    = r_prev;
        n_peak    = r_peak;
        n_rms     = r_rms;
        n_delta   = r_delta;
        n_lf      = r_lf;
        n_lr      = r_lr;
        n_energy  = r_energy;
        n_onset   = r_onset;
        log_start = 1'b0;
        log_x     = floor_q;
        div_start = 1'b0;
        div_hi    = 32'(nmul[LOG_W+15:16]);
        div_lo    = nmul[15:0];
        div_den   = 32'(den);
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_rms = i_raw_rms;
                    if (i_mic_enabled) begin
                        n_state = S_CEIL;
                    end else begin
                        n_energy = GLOW_LEVEL;
                        n_onset  = 16'd0;
                        n_state  = S_OUT;
                    end
                end
            end
            S_CEIL: begin
                // decay toward base, jump up to a louder frame
                n_ceil  = (rms_q > ceil_dec) ? rms_q : ceil_dec;
                n_state = S_PEAK;
            end
            S_PEAK: begin
                n_delta = delta;
                n_prev  = r_rms;
                n_peak  = (dq > decayed) ? dq : decayed;
                n_state = S_ECHK;
            end
            S_ECHK: begin
                priority if (r_rms < floor_eff) begin
                    n_energy = 16'd0;
                    n_state  = S_ONSET;
                end else if (r_ceil <= floor_q) begin
                    n_energy = FULL_SCALE;
                    n_state  = S_ONSET;
                end else begin
                    log_start = 1'b1;
                    log_x     = floor_q;
                    n_state   = S_LF;
                end
            end
            S_LF: begin
                if (log_res.done) begin
                    n_lf      = log_res.value;
                    log_start = 1'b1;
                    log_x     = rms_q;
                    n_state   = S_LR;
                end
            end
            S_LR: begin
                if (log_res.done) begin
                    n_lr      = log_res.value;
                    log_start = 1'b1;
                    log_x     = r_ceil;
                    n_state   = S_LC;
                end
            end
            S_LC: begin
                if (log_res.done) begin
                    // ratio of one or more saturates without dividing
                    priority if (log_res.value <= r_lf) begin
                        n_energy = FULL_SCALE;
                        n_state  = S_ONSET;
                    end else if (num >= den) begin
                        n_energy = FULL_SCALE;
                        n_state  = S_ONSET;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_EDIV;
                    end
                end
            end
            S_EDIV: begin
                if (div_res.done) begin
                    n_energy = div_res.quot;
                    n_state  = S_ONSET;
                end
            end
            S_ONSET: begin
                if (r_peak == 32'd0) begin
                    n_onset = 16'd0;
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    div_hi    = {r_delta, 16'd0} - 32'(r_delta);
                    div_lo    = 16'd0;
                    div_den   = r_peak;
                    n_state   = S_ODIV;
                end
            end
            S_ODIV: begin
                if (div_res.done) begin
                    n_onset = div_res.quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once transferred
    always_comb begin
        n_out_energy = r_out_energy;
        n_out_onset  = r_out_onset;
        n_out_valid  = r_out_valid;
        if (out_load) begin
            n_out_energy = r_energy;
            n_out_onset  = r_onset;
            n_out_valid  = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ceil      <= {BASE_RST, 16'd0};
            r_prev      <= 16'd0;
            r_peak      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ceil      <= n_ceil;
            r_prev      <= n_prev;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
        end
        r_rms        <= n_rms;
        r_delta      <= n_delta;
        r_lf         <= n_lf;
        r_lr         <= n_lr;
        r_energy     <= n_energy;
        r_onset      <= n_onset;
        r_out_energy <= n_out_energy;
        r_out_onset  <= n_out_onset;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_energy_level = r_out_energy;
    assign o_onset_level  = r_out_onset;

endmodule

// ===== tb/audio_energy_onset_tracker_top_test.sv =====
// Self-checking testbench for the audio energy and onset tracker: random frames, register sweeps.
module audio_energy_onset_tracker_top_test;
    import aeot_pkg::*;

    // Bits of the log result fraction and of the normalized mantissa
    localparam int LOG_FRAC  = 16;
    localparam int MANT_Q    = 30;
    localparam int RAND_BLKS = 6;
    localparam int BLK_ITEMS = 185;

    typedef struct packed {
        logic [15:0] rms;
        logic        mic;
    } t_frame;

    typedef struct packed {
        logic [15:0] energy;
        logic [15:0] onset;
    } t_levels;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_raw_rms = 16'd0;
    logic        i_mic_enabled = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_energy_level;
    logic [15:0] o_onset_level;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and tracker state of the predictor
    logic [15:0] floor_reg;
    logic [15:0] base_reg;
    logic [15:0] ceil_decay_reg;
    logic [15:0] peak_decay_reg;
    logic [31:0] ceiling_q;
    logic [15:0] prior_rms;
    logic [31:0] change_peak_q;

    t_frame      pending_frames[$];
    t_levels     expected_levels[$];
    logic [15:0] last_queued_rms = 16'd0;

    int          send_idle_pct = 27;
    int          recv_idle_pct = 62;
    bit          sender_hold = 1'b0;
    int          hold_off_cycles = 0;
    bit          took_frame = 1'b0;

    int unsigned queued_frames = 0;
    int unsigned popped_frames = 0;
    int unsigned accepted_frames = 0;
    int unsigned mic_off_frames = 0;
    int unsigned results_checked = 0;
    int unsigned settings_applied = 0;
    int unsigned mismatch_count = 0;

    audio_energy_onset_tracker_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_rms      (i_raw_rms),
        .i_mic_enabled  (i_mic_enabled),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_energy_level (o_energy_level),
        .o_onset_level  (o_onset_level),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // log2 of a Q16.16 value by repeated squaring of a Q1.30 mantissa
    function automatic logic [63:0] log2_q16(input logic [63:0] x);
        int          msb;
        int          step;
        logic [63:0] mant;
        logic [63:0] acc;
        if (x < 64'h10000) return 64'd0;
        msb = 0;
        while (msb < 63 && (x >> (msb + 1)) != 64'd0) msb++;
        if (msb >= MANT_Q) mant = x >> (msb - MANT_Q);
        else mant = x << (MANT_Q - msb);
        acc = 64'(msb - 16);
        for (step = 0; step < LOG_FRAC; step++) begin
            mant = (mant * mant) >> MANT_Q;
            acc = acc << 1;
            if (mant >= (64'd2 << MANT_Q)) begin
                mant = mant >> 1;
                acc[0] = 1'b1;
            end
        end
        return acc;
    endfunction

    // Advance the tracker by one frame and return the levels it should produce
    function automatic t_levels track_frame(input t_frame f);
        t_levels     lv;
        logic [63:0] decayed;
        logic [63:0] base_q;
        logic [63:0] rms_q;
        logic [63:0] floor_q;
        logic [63:0] lf;
        logic [63:0] lr;
        logic [63:0] lc;
        logic [63:0] num;
        logic [63:0] quot;
        logic [63:0] dq;
        logic [15:0] floor_eff;
        logic [15:0] delta;
        if (!f.mic) begin
            lv.energy = GLOW_LEVEL;
            lv.onset = 16'd0;
            return lv;
        end

        // Decay the ceiling toward its base, then jump to a louder frame
        decayed = (64'(ceiling_q) * 64'(ceil_decay_reg)) >> 16;
        base_q = 64'(base_reg) << 16;
        ceiling_q = 32'((decayed > base_q) ? decayed : base_q);
        rms_q = 64'(f.rms) << 16;
        if (rms_q > 64'(ceiling_q)) ceiling_q = 32'(rms_q);

        // Normalize log energy between floor and ceiling
        floor_eff = (floor_reg == 16'd0) ? 16'd1 : floor_reg;
        floor_q = 64'(floor_eff) << 16;
        if (f.rms < floor_eff) begin
            lv.energy = 16'd0;
        end else if (64'(ceiling_q) <= floor_q) begin
            lv.energy = FULL_SCALE;
        end else begin
            lf = log2_q16(floor_q);
            lr = log2_q16(rms_q);
            lc = log2_q16(64'(ceiling_q));
            if (lc <= lf) begin
                lv.energy = FULL_SCALE;
            end else begin
                num = (lr > lf) ? lr - lf : 64'd0;
                quot = (num * 64'd65535) / (lc - lf);
                lv.energy = (quot > 64'd65535) ? FULL_SCALE : quot[15:0];
            end
        end

        // Scale frame-to-frame change by the decaying change peak
        delta = (f.rms >= prior_rms) ? f.rms - prior_rms : prior_rms - f.rms;
        prior_rms = f.rms;
        decayed = (64'(change_peak_q) * 64'(peak_decay_reg)) >> 16;
        dq = 64'(delta) << 16;
        change_peak_q = 32'((dq > decayed) ? dq : decayed);
        if (change_peak_q == 32'd0) begin
            lv.onset = 16'd0;
        end else begin
            quot = (dq * 64'd65535) / 64'(change_peak_q);
            lv.onset = (quot > 64'd65535) ? FULL_SCALE : quot[15:0];
        end
        return lv;
    endfunction

    // Pick a frame biased toward the floor, repeats, extremes and slow swells
    function automatic t_frame random_frame();
        t_frame f;
        int     pick;
        int     v;
        pick = $urandom_range(99);
        f.mic = 1'b1;
        f.rms = 16'($urandom);
        if (pick < 10) begin
            f.mic = 1'b0;
        end else if (pick < 30) begin
            v = int'(f.rms);
        end else if (pick < 45) begin
            v = int'(floor_reg) + int'($urandom_range(6)) - 3;
        end else if (pick < 55) begin
            v = int'(last_queued_rms);
        end else if (pick < 65) begin
            case ($urandom_range(2))
                0: v = 0;
                1: v = 1;
                default: v = 65535;
            endcase
        end else if (pick < 80) begin
            v = int'($urandom_range(2000));
        end else begin
            v = int'(last_queued_rms) + int'($urandom_range(4000)) - 2000;
        end
        if (pick >= 10) begin
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            f.rms = 16'(v);
        end
        return f;
    endfunction

    task automatic queue_frame(input t_frame f);
        pending_frames.push_back(f);
        last_queued_rms = f.rms;
        queued_frames++;
    endtask

    // Write one register through a setup phase and an access phase
    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FLOOR:  floor_reg = val;
            REG_BASE:   base_reg = val;
            REG_CDECAY: ceil_decay_reg = val;
            REG_PDECAY: peak_decay_reg = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] fl, input logic [15:0] bs,
                                  input logic [15:0] cd, input logic [15:0] pd);
        write_register(REG_FLOOR, fl);
        write_register(REG_BASE, bs);
        write_register(REG_CDECAY, cd);
        write_register(REG_PDECAY, pd);
        settings_applied++;
    endtask

    // Hold until every queued frame is accepted and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_frames != queued_frames || expected_levels.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_decay();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(65535, 60000));
            2: return 16'hFFFF;
            default: return 16'($urandom_range(65535, 65400));
        endcase
    endfunction

    // Offer frames at the falling edge; hold the payload until it transfers
    always @(negedge i_clk) begin : frame_driver
        t_frame next_frame;
        if (i_rst_n && (!i_in_valid || took_frame)) begin
            if (pending_frames.size() != 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct) begin
                next_frame = pending_frames.pop_front();
                popped_frames++;
                i_in_valid <= 1'b1;
                i_raw_rms <= next_frame.rms;
                i_mic_enabled <= next_frame.mic;
            end else begin
                i_in_valid <= 1'b0;
                i_raw_rms <= 16'($urandom);
                i_mic_enabled <= 1'($urandom);
            end
        end
    end

    // Stall the output at random, or for a long counted stretch when asked
    always @(negedge i_clk) begin : result_stall
        if (hold_off_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Predict accepted frames and check output transfers at the rising edge
    always @(posedge i_clk) begin : level_monitor
        t_levels want;
        t_frame  seen_frame;
        if (!i_rst_n) begin
            took_frame = 1'b0;
        end else begin
            took_frame = i_in_valid && !o_in_stall;
            if (took_frame) begin
                seen_frame.rms = i_raw_rms;
                seen_frame.mic = i_mic_enabled;
                expected_levels.push_back(track_frame(seen_frame));
                accepted_frames++;
                if (!seen_frame.mic) mic_off_frames++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_levels.size() == 0) begin
                    $error("result transfer with no frame outstanding: energy %0d onset %0d",
                           o_energy_level, o_onset_level);
                    mismatch_count++;
                end else begin
                    want = expected_levels.pop_front();
                    results_checked++;
                    if (o_energy_level !== want.energy) begin
                        $error("energy_level: expected %0d, got %0d",
                               want.energy, o_energy_level);
                        mismatch_count++;
                    end
                    if (o_onset_level !== want.onset) begin
                        $error("onset_level: expected %0d, got %0d",
                               want.onset, o_onset_level);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : run_limit
        #8000000;
        $display("run timed out with %0d results outstanding", expected_levels.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int          blk;
        int          n;
        int unsigned mark;
        t_frame      f;

        floor_reg = FLOOR_RST;
        base_reg = BASE_RST;
        ceil_decay_reg = CDECAY_RST;
        peak_decay_reg = PDECAY_RST;
        ceiling_q = 32'(BASE_RST) << 16;
        prior_rms = 16'd0;
        change_peak_q = 32'd0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset settings: zero change peak, floor edges, ceiling jump, mic off
        apply_settings(FLOOR_RST, BASE_RST, CDECAY_RST, PDECAY_RST);
        queue_frame('{16'd0, 1'b1});
        queue_frame('{16'd0, 1'b1});
        queue_frame('{16'd65535, 1'b1});
        queue_frame('{16'd65535, 1'b1});
        queue_frame('{16'd0, 1'b1});
        queue_frame('{16'd4000, 1'b1});
        queue_frame('{16'd3999, 1'b1});
        queue_frame('{16'd4001, 1'b1});
        queue_frame('{16'd50000, 1'b1});
        queue_frame('{16'd1, 1'b1});
        queue_frame('{16'd12345, 1'b0});
        queue_frame('{16'd65535, 1'b0});
        queue_frame('{16'd0, 1'b0});
        queue_frame('{16'd30000, 1'b1});
        queue_frame('{16'd30000, 1'b1});
        wait_drained();

        // Zero floor and base with no decay: ceiling follows each frame
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        queue_frame('{16'd0, 1'b1});
        queue_frame('{16'd1, 1'b1});
        queue_frame('{16'd2, 1'b1});
        queue_frame('{16'd65535, 1'b1});
        queue_frame('{16'd1, 1'b0});
        queue_frame('{16'd0, 1'b1});
        wait_drained();

        // Floor at full scale keeps the ceiling at or below it
        apply_settings(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
        queue_frame('{16'd65535, 1'b1});
        queue_frame('{16'd65534, 1'b1});
        queue_frame('{16'd100, 1'b1});
        queue_frame('{16'd65535, 1'b1});
        wait_drained();

        // Random frames in blocks; each block applies settings (the reset values in the last block) and an idle pattern
        for (blk = 0; blk < RAND_BLKS; blk++) begin
            send_idle_pct = (blk < 2) ? 27 : (blk < 4) ? 62 : 0;
            recv_idle_pct = (blk < 2) ? 62 : (blk < 4) ? 27 : 0;
            if (blk == RAND_BLKS - 1) begin
                apply_settings(FLOOR_RST, BASE_RST, CDECAY_RST, PDECAY_RST);
            end else begin
                apply_settings(($urandom_range(9) == 0) ? 16'd1 : 16'($urandom_range(20000, 1)),
                               16'($urandom_range(65535, 1)), pick_decay(), pick_decay());
            end
            mark = accepted_frames;
            for (n = 0; n < BLK_ITEMS; n++) begin
                f = random_frame();
                queue_frame(f);
            end
            if (blk == 0) begin
                // Block the output long enough for the input to back up
                while (accepted_frames < mark + 40) @(negedge i_clk);
                @(posedge i_clk);
                hold_off_cycles = 400;
                while (accepted_frames < mark + 100) @(negedge i_clk);
                // Pause the sender until every result is back
                sender_hold = 1'b1;
                do @(negedge i_clk);
                while (accepted_frames != popped_frames || expected_levels.size() != 0);
                repeat (40) @(negedge i_clk);
                sender_hold = 1'b0;
            end
            wait_drained();
        end

        repeat (120) @(posedge i_clk);
        if (expected_levels.size() != 0) begin
            $error("%0d expected results never arrived", expected_levels.size());
            mismatch_count++;
        end
        $display("Covered %0d frames (%0d with the mic off) under %0d register settings,",
                 accepted_frames, mic_off_frames, settings_applied);
        $display("with %0d results compared and %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
